// ===== design/stcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stcr_pkg;

    localparam int ROW_W   = 7;
    localparam int COL_W   = 8;
    localparam int COLOR_W = 2;
    localparam int KIND_W  = 2;
    localparam int RUN_CNT_W = 4;
    localparam int ROWS    = 1 << ROW_W;

    // Last run slot of one point, the final column pixel included.
    localparam logic [RUN_CNT_W-1:0] LAST_SLOT      = 4'd15;
    localparam logic [RUN_CNT_W-1:0] LAST_SEG_SLOT  = 4'd14;

    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ON    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ABOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BELOW = 2'd2;

    localparam logic [1:0] CFG_TOP_ROW     = 2'd0;
    localparam logic [1:0] CFG_BOTTOM_ROW  = 2'd1;
    localparam logic [1:0] CFG_CENTER_ROW  = 2'd2;
    localparam logic [1:0] CFG_LEFT_COLUMN = 2'd3;

    typedef struct packed {
        logic               seg_ok;
        logic               erase;
        logic               up;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row_start;
        logic [ROW_W-1:0]   row_end;
        logic [COLOR_W-1:0] grid_color;
        logic               end_pix;
        logic [COL_W-1:0]   end_column;
        logic [ROW_W-1:0]   end_row;
        logic [COLOR_W-1:0] end_color;
    } t_job;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ROW_W-1:0]   row_last;
        logic [ROW_W-1:0]   row_first;
        logic [COL_W-1:0]   column;
    } t_run;

endpackage

`default_nettype wire

// ===== design/stcr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stcr_front #(
    parameter int COLUMNS     = 95,
    parameter int GRID_PERIOD = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire                          i_cmd,
    input  wire  [stcr_pkg::KIND_W-1:0]  i_point_kind,
    input  wire  [stcr_pkg::ROW_W-1:0]   i_point_row,
    input  wire  [stcr_pkg::ROW_W-1:0]   i_top_row,
    input  wire  [stcr_pkg::ROW_W-1:0]   i_bottom_row,
    input  wire  [stcr_pkg::COL_W-1:0]   i_left_column,
    input  wire                          i_queue_full,
    output logic                         o_push,
    output stcr_pkg::t_job               o_job
);
    import stcr_pkg::*;

    localparam int PH_W = (GRID_PERIOD > 1) ? $clog2(GRID_PERIOD) : 1;
    localparam logic [ROW_W-1:0] LAST_COL_IDX = ROW_W'(COLUMNS - 1);
    localparam logic [PH_W-1:0]  LAST_PHASE   = PH_W'(GRID_PERIOD - 1);

    logic [KIND_W-1:0] r_prev_kind, n_prev_kind;
    logic [ROW_W-1:0]  r_prev_row, n_prev_row;
    logic [ROW_W-1:0]  r_count, n_count;
    logic [PH_W-1:0]   r_phase, n_phase;

    logic              w_accept;
    logic [KIND_W-1:0] w_kb;
    logic              w_final;
    logic              w_ok;
    logic              w_up;
    logic [ROW_W-1:0]  w_s;
    logic [ROW_W-1:0]  w_e;
    logic [ROW_W-1:0]  a;
    logic [ROW_W-1:0]  b;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_kb     = (i_point_kind >= KIND_BELOW) ? KIND_BELOW : i_point_kind;
    assign w_final  = (r_count == LAST_COL_IDX);
    assign a        = r_prev_row;
    assign b        = i_point_row;

    always_comb begin
        w_ok = 1'b0;
        w_up = 1'b1;
        w_s  = a;
        w_e  = b;
        if (r_prev_kind == KIND_ON && w_kb == KIND_ON) begin
            w_ok = (a != b);
            w_up = (a < b);
            w_e  = (a < b) ? b - 7'd1 : b + 7'd1;
        end else if (r_prev_kind == KIND_ON && w_kb == KIND_ABOVE) begin
            w_e  = i_top_row;
            w_up = 1'b0;
            w_ok = (a >= i_top_row);
        end else if (r_prev_kind == KIND_ON && w_kb == KIND_BELOW) begin
            w_e  = i_bottom_row;
            w_ok = (a <= i_bottom_row);
        end else if (r_prev_kind == KIND_ABOVE && w_kb == KIND_ON) begin
            w_s  = i_top_row;
            w_e  = b - 7'd1;
            w_ok = (b > i_top_row);
        end else if (r_prev_kind == KIND_BELOW && w_kb == KIND_ON) begin
            w_s  = i_bottom_row;
            w_e  = b + 7'd1;
            w_up = 1'b0;
            w_ok = (b < i_bottom_row);
        end else if (r_prev_kind == KIND_BELOW && w_kb == KIND_ABOVE) begin
            w_s  = i_bottom_row;
            w_e  = i_top_row;
            w_up = 1'b0;
            w_ok = (i_bottom_row >= i_top_row);
        end else if (r_prev_kind == KIND_ABOVE && w_kb == KIND_BELOW) begin
            w_s  = i_top_row;
            w_e  = i_bottom_row;
            w_ok = (i_top_row <= i_bottom_row);
        end
    end

    always_comb begin
        o_job.seg_ok     = w_ok && (r_count != '0);
        o_job.erase      = i_cmd;
        o_job.up         = w_up;
        o_job.column     = i_left_column + COL_W'(r_count) - 8'd1;
        o_job.row_start  = w_s;
        o_job.row_end    = w_e;
        // The previous column is a vertical grid line when this column starts a period.
        o_job.grid_color = (r_phase == '0) ? COLOR_WHITE : COLOR_BLACK;
        o_job.end_pix    = w_final && (w_kb == KIND_ON);
        o_job.end_column = i_left_column + COL_W'(COLUMNS - 1);
        o_job.end_row    = b;
        o_job.end_color  = i_cmd ? COLOR_WHITE : COLOR_YELLOW;
    end

    assign o_push = w_accept && (o_job.seg_ok || o_job.end_pix);

    always_comb begin
        n_prev_kind = r_prev_kind;
        n_prev_row  = r_prev_row;
        n_count     = r_count;
        n_phase     = r_phase;
        if (w_accept) begin
            n_prev_kind = w_kb;
            n_prev_row  = b;
            if (w_final) begin
                n_count = '0;
                n_phase = '0;
            end else begin
                n_count = r_count + 7'd1;
                n_phase = (r_phase == LAST_PHASE) ? '0 : r_phase + PH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_kind <= KIND_ON;
            r_prev_row  <= '0;
            r_count     <= '0;
            r_phase     <= '0;
        end else begin
            r_prev_kind <= n_prev_kind;
            r_prev_row  <= n_prev_row;
            r_count     <= n_count;
            r_phase     <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== design/stcr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stcr_fifo #(
    parameter int DEPTH = 4
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  stcr_pkg::t_job  i_job,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_not_empty,
    output stcr_pkg::t_job  o_job
);
    import stcr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    assign o_full      = (r_cnt == FULL_CNT);
    assign o_not_empty = (r_cnt != '0);
    assign o_job       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== design/stcr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stcr_back #(
    parameter int GRID_PERIOD = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_job_valid,
    input  stcr_pkg::t_job              i_job,
    output logic                        o_pop,
    input  wire  [stcr_pkg::ROW_W-1:0]  i_center_row,
    input  wire  [stcr_pkg::ROW_W-1:0]  i_bottom_row,
    output logic                        o_valid,
    input  wire                         i_ready,
    output stcr_pkg::t_run              o_run,
    output logic                        o_last
);
    import stcr_pkg::*;

    localparam int MOD_W = (GRID_PERIOD > 1) ? $clog2(GRID_PERIOD) : 1;
    localparam logic [7:0] GP8 = 8'(GRID_PERIOD);
    localparam bit HAS_GRID = (GRID_PERIOD > 2);

    logic [MOD_W-1:0] w_mod [ROWS];

    for (genvar g = 0; g < ROWS; g++) begin : g_mod
        assign w_mod[g] = MOD_W'(g % GRID_PERIOD);
    end

    logic                 r_busy;
    logic                 r_in_end;
    logic                 r_out_valid;
    logic                 r_out_last;
    t_run                 r_out;
    t_job                 r_job;
    logic [ROW_W-1:0]     r_y;
    logic [RUN_CNT_W-1:0] r_cnt;

    logic                 w_adv;
    logic                 w_step;
    logic                 w_seg_done;
    logic                 w_job_done;
    logic                 w_last;
    t_run                 w_run;
    logic [ROW_W-1:0]     w_next_y;

    logic [7:0]           y8;
    logic [7:0]           e8;
    logic [7:0]           c8;
    logic [7:0]           b8;
    logic [7:0]           m8;
    logic [7:0]           w_dg;
    logic [7:0]           w_lim;
    logic                 w_is_c;
    logic                 w_is_b;
    logic                 w_is_g;
    logic                 w_special;
    logic [ROW_W-1:0]     w_seg_last;
    logic [COLOR_W-1:0]   w_seg_color;

    assign y8 = {1'b0, r_y};
    assign e8 = {1'b0, r_job.row_end};
    assign c8 = {1'b0, i_center_row};
    assign b8 = {1'b0, i_bottom_row};
    assign m8 = 8'(w_mod[r_y]);

    assign w_is_c    = (r_y == i_center_row);
    assign w_is_b    = (r_y == i_bottom_row);
    assign w_is_g    = HAS_GRID && (m8 == 8'd2);
    assign w_special = w_is_c || w_is_g || w_is_b;

    // Erase walk: one run from the current row up to the row before the next
    // special row or the segment end, whichever is first; a special row is a run alone.
    always_comb begin
        if (r_job.up) begin
            w_dg  = (m8 < 8'd2) ? 8'd2 - m8 : GP8 + 8'd2 - m8;
            w_lim = e8 - y8;
        end else begin
            w_dg  = (m8 > 8'd2) ? m8 - 8'd2 : m8 + GP8 - 8'd2;
            w_lim = y8 - e8;
        end
        if (HAS_GRID && (w_dg - 8'd1 < w_lim)) begin
            w_lim = w_dg - 8'd1;
        end
        if (r_job.up && c8 > y8 && (c8 - y8 - 8'd1 < w_lim)) begin
            w_lim = c8 - y8 - 8'd1;
        end
        if (!r_job.up && c8 < y8 && (y8 - c8 - 8'd1 < w_lim)) begin
            w_lim = y8 - c8 - 8'd1;
        end
        if (r_job.up && b8 > y8 && (b8 - y8 - 8'd1 < w_lim)) begin
            w_lim = b8 - y8 - 8'd1;
        end
        if (!r_job.up && b8 < y8 && (y8 - b8 - 8'd1 < w_lim)) begin
            w_lim = y8 - b8 - 8'd1;
        end
        if (w_special) begin
            w_lim = 8'd0;
        end
        w_seg_last = r_job.up ? ROW_W'(y8 + w_lim) : ROW_W'(y8 - w_lim);
        if (w_is_c) begin
            w_seg_color = COLOR_YELLOW;
        end else if (w_special) begin
            w_seg_color = COLOR_WHITE;
        end else begin
            w_seg_color = r_job.grid_color;
        end
    end

    always_comb begin
        w_run.column    = r_job.column;
        w_run.row_first = r_y;
        w_run.row_last  = r_job.row_end;
        w_run.color     = COLOR_YELLOW;
        w_seg_done      = 1'b1;
        w_job_done      = 1'b1;
        w_last          = 1'b1;
        w_next_y        = r_y;
        if (r_in_end) begin
            w_run.column    = r_job.end_column;
            w_run.row_first = r_job.end_row;
            w_run.row_last  = r_job.end_row;
            w_run.color     = r_job.end_color;
        end else begin
            if (r_job.erase) begin
                w_run.row_last = w_seg_last;
                w_run.color    = w_seg_color;
            end
            w_next_y   = r_job.up ? w_run.row_last + 7'd1 : w_run.row_last - 7'd1;
            // A segment stops early once the result slots run out.
            w_seg_done = (w_run.row_last == r_job.row_end) ||
                         (r_cnt == (r_job.end_pix ? LAST_SEG_SLOT : LAST_SLOT));
            w_job_done = w_seg_done && !r_job.end_pix;
            w_last     = w_job_done;
        end
    end

    assign w_adv  = !r_out_valid || i_ready;
    assign w_step = r_busy && w_adv;
    assign o_pop  = i_job_valid && (!r_busy || (w_step && w_job_done));

    assign o_valid = r_out_valid;
    assign o_run   = r_out;
    assign o_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_in_end    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= w_step;
            end
            if (o_pop) begin
                r_busy   <= 1'b1;
                r_in_end <= !i_job.seg_ok;
                r_cnt    <= '0;
            end else if (w_step) begin
                if (w_job_done) begin
                    r_busy <= 1'b0;
                end else if (w_seg_done) begin
                    r_in_end <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + RUN_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out      <= w_run;
            r_out_last <= w_last;
        end
        if (o_pop) begin
            r_job <= i_job;
            r_y   <= i_job.row_start;
        end else if (w_step) begin
            r_y <= w_next_y;
        end
    end

endmodule

`default_nettype wire

// ===== design/scope_trace_column_rasterizer_core.sv =====
// Turns the trace points of one frame, one point per screen column, into
// vertical pixel runs for a display write port.
// Input channel: one point per transfer; tuser carries the draw or erase
// command and the point kind, tdata the point row. The first point of a frame
// only sets the start; every later point yields the runs of the previous
// column, and the last column of the frame adds a single pixel for an on-screen point.
// Output channel: one run per transfer (column, first row, last row, colour),
// with tlast on the final run caused by a point. A point that causes no run
// gives no transfer.
// The front part takes one point per cycle into a small job queue while the
// queue is not full. The back part emits one run per cycle while the receiver
// is ready; a queued point makes between one and sixteen runs. The first run of a
// point passes the job queue, the back part's job register and its output register.
// The output is a single register; when the receiver stalls it holds, the back
// part waits and the input keeps accepting until the queue is full.
// Reset restores the default rows and left column and starts a new frame.
// Configuration writes take effect at the next edge and must be made while idle; nothing enforces it.
`timescale 1ns / 1ps
`default_nettype none

module scope_trace_column_rasterizer_core #(
    parameter int COLUMNS     = 95,
    parameter int GRID_PERIOD = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_addr,
    input  wire  [7:0]  i_cfg_wdata,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,  // point_row[6:0], zero pad
    input  wire  [2:0]  i_s_axis_tuser,  // cmd[0], point_kind[2:1]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // column[7:0], row_first[14:8],
                                         // row_last[21:15], color[23:22]
    output logic        o_m_axis_tlast
);
    import stcr_pkg::*;

    logic [ROW_W-1:0] r_top_row;
    logic [ROW_W-1:0] r_bottom_row;
    logic [ROW_W-1:0] r_center_row;
    logic [COL_W-1:0] r_left_column;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_not_empty;
    t_job  w_job_in;
    t_job  w_job_out;
    t_run  w_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_row     <= 7'd3;
            r_bottom_row  <= 7'd97;
            r_center_row  <= 7'd50;
            r_left_column <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TOP_ROW:     r_top_row     <= i_cfg_wdata[ROW_W-1:0];
                CFG_BOTTOM_ROW:  r_bottom_row  <= i_cfg_wdata[ROW_W-1:0];
                CFG_CENTER_ROW:  r_center_row  <= i_cfg_wdata[ROW_W-1:0];
                CFG_LEFT_COLUMN: r_left_column <= i_cfg_wdata;
                default:         r_left_column <= r_left_column;
            endcase
        end
    end

    stcr_front #(
        .COLUMNS     (COLUMNS),
        .GRID_PERIOD (GRID_PERIOD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_cmd         (i_s_axis_tuser[0]),
        .i_point_kind  (i_s_axis_tuser[2:1]),
        .i_point_row   (i_s_axis_tdata[ROW_W-1:0]),
        .i_top_row     (r_top_row),
        .i_bottom_row  (r_bottom_row),
        .i_left_column (r_left_column),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_job         (w_job_in)
    );

    stcr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_job_in),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_job       (w_job_out)
    );

    stcr_back #(
        .GRID_PERIOD (GRID_PERIOD)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_not_empty),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .i_center_row (r_center_row),
        .i_bottom_row (r_bottom_row),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_run        (w_run),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = w_run;

endmodule

`default_nettype wire

// ===== tb/sv/scope_trace_column_rasterizer_core_tb.sv =====
`timescale 1ns / 1ps

module scope_trace_column_rasterizer_core_tb;

    import stcr_pkg::*;

    localparam int COLUMNS        = 95;
    localparam int GRID_PERIOD    = 16;
    localparam int MAX_RUNS       = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 19;
    localparam int PAUSE_ITEM     = 10;
    localparam int DIRECTED_N     = 25;

    localparam logic       CMD_DRAW       = 1'b0;
    localparam logic       CMD_ERASE      = 1'b1;
    localparam logic [1:0] KIND_BELOW_ALT = 2'd3;

    typedef enum logic [1:0] {DUE_PREDICTED, DUE_NONE, DUE_ONE} t_due_mode;

    typedef struct packed {
        logic       cmd;
        logic [1:0] kind;
        logic [6:0] row;
        t_due_mode  how;
        t_run       fixed;
    } t_probe;

    typedef struct packed {
        t_run run;
        logic last;
    } t_run_due;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic [2:0]  i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    scope_trace_column_rasterizer_core #(
        .COLUMNS     (COLUMNS),
        .GRID_PERIOD (GRID_PERIOD)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    logic [6:0] top_clip    = 7'd3;
    logic [6:0] bottom_clip = 7'd97;
    logic [6:0] zero_row    = 7'd50;
    logic [7:0] x_origin    = 8'd4;
    logic [1:0] trace_kind  = KIND_ON;
    logic [6:0] trace_row   = '0;
    logic [6:0] trace_col   = '0;

    t_run     seg_runs [MAX_RUNS];
    int       seg_n;
    t_run_due runs_due [$];
    int       errors = 0;
    int       idle_cycles = 0;
    logic     steady = 1'b0;
    t_run     seen;
    t_run_due want;

    t_probe probes [DIRECTED_N] = '{
        '{CMD_DRAW,  KIND_ON,        7'd10,  DUE_NONE,      '0},
        '{CMD_DRAW,  KIND_ON,        7'd20,  DUE_ONE,
          '{COLOR_YELLOW, 7'd19, 7'd10, 8'd4}},
        '{CMD_DRAW,  KIND_ON,        7'd20,  DUE_NONE,      '0},
        '{CMD_DRAW,  KIND_ABOVE,     7'd0,   DUE_ONE,
          '{COLOR_YELLOW, 7'd3, 7'd20, 8'd6}},
        '{CMD_DRAW,  KIND_BELOW,     7'd0,   DUE_ONE,
          '{COLOR_YELLOW, 7'd97, 7'd3, 8'd7}},
        '{CMD_DRAW,  KIND_BELOW_ALT, 7'd0,   DUE_NONE,      '0},
        '{CMD_DRAW,  KIND_ON,        7'd127, DUE_NONE,      '0},
        '{CMD_DRAW,  KIND_ON,        7'd0,   DUE_ONE,
          '{COLOR_YELLOW, 7'd1, 7'd127, 8'd10}},
        '{CMD_ERASE, KIND_ABOVE,     7'd0,   DUE_NONE,      '0},
        '{CMD_ERASE, KIND_ON,        7'd60,  DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_BELOW,     7'd0,   DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_ABOVE,     7'd0,   DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_ON,        7'd127, DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_ON,        7'd0,   DUE_PREDICTED, '0},
        '{CMD_DRAW,  KIND_ABOVE,     7'd0,   DUE_NONE,      '0},
        '{CMD_ERASE, KIND_ON,        7'd90,  DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_ON,        7'd2,   DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_ON,        7'd50,  DUE_PREDICTED, '0},
        '{CMD_DRAW,  KIND_ON,        7'd2,   DUE_ONE,
          '{COLOR_YELLOW, 7'd3, 7'd50, 8'd21}},
        '{CMD_ERASE, KIND_BELOW,     7'd0,   DUE_PREDICTED, '0},
        '{CMD_DRAW,  KIND_ON,        7'd96,  DUE_ONE,
          '{COLOR_YELLOW, 7'd97, 7'd97, 8'd23}},
        '{CMD_ERASE, KIND_ON,        7'd127, DUE_PREDICTED, '0},
        '{CMD_DRAW,  KIND_BELOW_ALT, 7'd0,   DUE_NONE,      '0},
        '{CMD_ERASE, KIND_ABOVE,     7'd0,   DUE_PREDICTED, '0},
        '{CMD_ERASE, KIND_BELOW,     7'd0,   DUE_PREDICTED, '0}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (steady || r < 60) return 0;
        if (r < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    task automatic add_run(input logic [7:0] col, input int f, input int l,
                           input logic [1:0] c, input int room);
        t_run r;
        if (seg_n < room) begin
            r.column    = col;
            r.row_first = 7'(f);
            r.row_last  = 7'(l);
            r.color     = c;
            seg_runs[seg_n] = r;
            seg_n++;
        end
    endtask

    task automatic rasterize_point(input logic erase, input logic [1:0] kind_in,
                                   input logic [6:0] b_row);
        logic [1:0] ka, kb, colc, sc;
        logic [6:0] idx;
        logic [7:0] col;
        logic       final_col, end_pix, ok, open, special;
        int         a, b, top, bot, s, e, dir, room, len, y, pf, pl, i;
        seg_n     = 0;
        kb        = (kind_in >= KIND_BELOW) ? KIND_BELOW : kind_in;
        ka        = trace_kind;
        a         = trace_row;
        b         = b_row;
        top       = top_clip;
        bot       = bottom_clip;
        final_col = (trace_col == 7'(COLUMNS - 1));
        end_pix   = final_col && kb == KIND_ON;
        room      = end_pix ? MAX_RUNS - 1 : MAX_RUNS;
        if (trace_col != 0) begin
            idx = trace_col - 7'd1;
            col = x_origin + {1'b0, idx};
            ok  = 1'b0;
            s   = 0;
            e   = 0;
            dir = 1;
            if (ka == KIND_ON && kb == KIND_ON) begin
                if (a < b) begin
                    s = a; e = b - 1; dir = 1; ok = 1'b1;
                end else if (a > b) begin
                    s = a; e = b + 1; dir = -1; ok = 1'b1;
                end
            end else if (ka == KIND_ON && kb == KIND_ABOVE) begin
                s = a; e = top; dir = -1; ok = (a >= top);
            end else if (ka == KIND_ON && kb == KIND_BELOW) begin
                s = a; e = bot; dir = 1; ok = (a <= bot);
            end else if (ka == KIND_ABOVE && kb == KIND_ON) begin
                s = top; e = b - 1; dir = 1; ok = (b > top);
            end else if (ka == KIND_BELOW && kb == KIND_ON) begin
                s = bot; e = b + 1; dir = -1; ok = (b < bot);
            end else if (ka == KIND_BELOW && kb == KIND_ABOVE) begin
                s = bot; e = top; dir = -1; ok = (bot >= top);
            end else if (ka == KIND_ABOVE && kb == KIND_BELOW) begin
                s = top; e = bot; dir = 1; ok = (top <= bot);
            end
            if (ok && !erase) begin
                add_run(col, s, e, COLOR_YELLOW, room);
            end else if (ok) begin
                colc = (idx % GRID_PERIOD == GRID_PERIOD - 1) ? COLOR_WHITE : COLOR_BLACK;
                open = 1'b0;
                pf   = 0;
                pl   = 0;
                len  = (e - s) * dir + 1;
                for (i = 0; i < len; i++) begin
                    y       = s + i * dir;
                    special = 1'b1;
                    sc      = COLOR_WHITE;
                    if (y == zero_row) sc = COLOR_YELLOW;
                    else if (y % GRID_PERIOD == 2 || y == bot) sc = COLOR_WHITE;
                    else special = 1'b0;
                    if (special) begin
                        if (open) add_run(col, pf, pl, colc, room);
                        open = 1'b0;
                        add_run(col, y, y, sc, room);
                    end else if (open) begin
                        pl = y;
                    end else begin
                        open = 1'b1;
                        pf   = y;
                        pl   = y;
                    end
                end
                if (open) add_run(col, pf, pl, colc, room);
            end
        end
        if (end_pix)
            add_run(x_origin + 8'(COLUMNS - 1), b, b,
                    erase ? COLOR_WHITE : COLOR_YELLOW, MAX_RUNS);
        trace_kind = kb;
        trace_row  = b_row;
        trace_col  = final_col ? 7'd0 : trace_col + 7'd1;
    endtask

    task automatic put_point(input logic cmd, input logic [1:0] kind, input logic [6:0] row,
                             input t_due_mode how, input t_run fixed);
        int       gap, j;
        t_run_due due;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, row};
        i_s_axis_tuser  <= {kind, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        rasterize_point(cmd, kind, row);
        if (how == DUE_PREDICTED) begin
            for (j = 0; j < seg_n; j++) begin
                due.run  = seg_runs[j];
                due.last = (j == seg_n - 1);
                runs_due.push_back(due);
            end
        end else if (how == DUE_ONE) begin
            due.run  = fixed;
            due.last = 1'b1;
            runs_due.push_back(due);
        end
    endtask

    task automatic settle(input int extra);
        i_s_axis_tvalid <= 1'b0;
        while (runs_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_TOP_ROW:     top_clip    = val[6:0];
            CFG_BOTTOM_ROW:  bottom_clip = val[6:0];
            CFG_CENTER_ROW:  zero_row    = val[6:0];
            CFG_LEFT_COLUMN: x_origin    = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [6:0] top, input logic [6:0] bot,
                              input logic [6:0] ctr, input logic [7:0] left);
        put_reg(CFG_TOP_ROW, {1'b0, top});
        put_reg(CFG_BOTTOM_ROW, {1'b0, bot});
        put_reg(CFG_CENTER_ROW, {1'b0, ctr});
        put_reg(CFG_LEFT_COLUMN, left);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen = t_run'(o_m_axis_tdata);
            if (runs_due.size() == 0) begin
                $display("%0t: unexpected run, expected none, got column %0d rows %0d..%0d",
                         $time, seen.column, seen.row_first, seen.row_last);
                errors++;
            end else begin
                want = runs_due.pop_front();
                check_field("column", want.run.column, seen.column);
                check_field("row_first", want.run.row_first, seen.row_first);
                check_field("row_last", want.run.row_last, seen.row_last);
                check_field("color", want.run.color, seen.color);
                check_field("last", want.last, o_m_axis_tlast);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("scope_trace_column_rasterizer_core_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin : sink
        int n;
        i_m_axis_tready = 1'b0;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int         p, i, v;
        logic       cmd_now;
        logic [1:0] kind_now;
        logic [6:0] row_now;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        cmd_now         = CMD_DRAW;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < DIRECTED_N; i++)
            put_point(probes[i].cmd, probes[i].kind, probes[i].row,
                      probes[i].how, probes[i].fixed);

        for (p = 0; p < 5; p++) begin
            settle(40);
            case (p)
                0: set_config(7'd0, 7'd127, 7'd64, 8'd255);
                1: set_config(7'd127, 7'd0, 7'd0, 8'd0);
                2: set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                              7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
                3: set_config(7'd0, 7'd127, 7'd127, 8'd128);
                default: set_config(7'($urandom_range(0, 40)), 7'($urandom_range(80, 127)),
                                    7'($urandom_range(0, 127)),
                                    8'($urandom_range(0, 255)));
            endcase
            steady = (p == 2);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PAUSE_ITEM) settle(0);
                if ($urandom_range(0, 9) == 0) cmd_now = ~cmd_now;
                v = int'($urandom_range(0, 99));
                if (v < 65) kind_now = KIND_ON;
                else if (v < 78) kind_now = KIND_ABOVE;
                else if (v < 91) kind_now = KIND_BELOW;
                else kind_now = KIND_BELOW_ALT;
                if (trace_col == 7'(COLUMNS - 1) && $urandom_range(0, 4) != 0)
                    kind_now = KIND_ON;
                if ($urandom_range(0, 1) == 1) begin
                    row_now = 7'($urandom_range(0, 127));
                end else begin
                    v = int'(trace_row) + int'($urandom_range(0, 40)) - 20;
                    if (v < 0) v = 0;
                    if (v > 127) v = 127;
                    row_now = 7'(v);
                end
                put_point(cmd_now, kind_now, row_now, DUE_PREDICTED, '0);
            end
        end

        settle(40);
        if (errors == 0) begin
            $display("scope_trace_column_rasterizer_core_tb OK");
        end else begin
            $display("scope_trace_column_rasterizer_core_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/stcr_pkg.sv
design/stcr_front.sv
design/stcr_fifo.sv
design/stcr_back.sv
design/scope_trace_column_rasterizer_core.sv
tb/sv/scope_trace_column_rasterizer_core_tb.sv
